// ===== rtl/mme_pkg.sv =====
// Shared types, constants and helpers for the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_W      = 16;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int DEPTH       = 64;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int RES_W       = 32;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT   = 2'd0,
        REG_INNER_COUNT = 2'd1,
        REG_COL_COUNT   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (r > DIM_W'(MAX_DIM))
            d = DIM_W'(MAX_DIM);
        else
            d = r;
        return d;
    endfunction

    // Saturate the wide accumulator to a signed 32-bit result
    function automatic logic [RES_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [RES_W-1:0] s;
        if (!v[ACC_W-1] && (|v[ACC_W-2:RES_W-1]))
            s = {1'b0, {(RES_W-1){1'b1}}};
        else if (v[ACC_W-1] && !(&v[ACC_W-2:RES_W-1]))
            s = {1'b1, {(RES_W-1){1'b0}}};
        else
            s = v[RES_W-1:0];
        return s;
    endfunction

endpackage

// ===== rtl/matrix_multiply_engine_unit.sv =====
// Matrix multiply engine: two element stores, one shared MAC unit and its sequencer.
// Load transactions leave the block in idle; tready stays high in idle.
// A compute transaction occupies the block until all rows*cols results are emitted, output
// stalls included: per result element, inner MAC issues through the one multiplier, a drain
// of the read and multiply stages, then the emit state.
// Reset: dimension registers go to 1, control clears; stores are undefined until loaded.
module matrix_multiply_engine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]         cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mme_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // element_index[5:0], element_value[21:6], zero[23:22]
    input  logic [mme_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[1:0]
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mme_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // product_value[31:0], result_row[34:32], result_col[37:35], zero[39:38]
    output logic                              m_axis_tlast   // last_of_run
);
    import mme_pkg::*;

    logic [DIM_W-1:0]   row_count_reg, inner_count_reg, col_count_reg;
    state_t             state_reg, state_next;
    logic [DIM_W-1:0]   rows_reg, rows_next, inner_reg, inner_next, cols_reg, cols_next;
    logic [IDX_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0]  row_base_reg, row_base_next, b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0]  a_addr;
    logic               issue, acc_clr, out_load;
    logic               rd_vld_reg, mul_vld_reg;
    logic signed [ELEM_W-1:0] a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic               out_vld_reg;
    logic [RES_W-1:0]   out_val_reg;
    logic [IDX_W-1:0]   out_row_reg, out_col_reg;
    logic               out_last_reg;
    logic               in_xfer, wr_a, wr_b, last_elem;
    logic [ADDR_W-1:0]  in_idx;
    logic [ELEM_W-1:0]  in_val;

    logic [ELEM_W-1:0]  mem_a [DEPTH];
    logic [ELEM_W-1:0]  mem_b [DEPTH];

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign in_idx  = s_axis_tdata[ADDR_W-1:0];
    assign in_val  = s_axis_tdata[ADDR_W+ELEM_W-1:ADDR_W];
    assign wr_a    = in_xfer && (s_axis_tuser == MODE_LOAD_A);
    assign wr_b    = in_xfer && (s_axis_tuser == MODE_LOAD_B);
    assign a_addr  = row_base_reg + {3'b000, k_reg};
    assign last_elem = ({1'b0, i_reg} == rows_reg - DIM_W'(1))
                    && ({1'b0, j_reg} == cols_reg - DIM_W'(1));

    // Hold dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= DIM_W'(1);
            inner_count_reg <= DIM_W'(1);
            col_count_reg   <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:   row_count_reg   <= cfg_data;
                REG_INNER_COUNT: inner_count_reg <= cfg_data;
                REG_COL_COUNT:   col_count_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Write loaded elements, read operands for the MAC
    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[in_idx] <= in_val;
        if (wr_b)
            mem_b[in_idx] <= in_val;
        a_q_reg <= mem_a[a_addr];
        b_q_reg <= mem_b[b_addr_reg];
    end

    // Sequencer state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_reg     <= DIM_W'(1);
            inner_reg    <= DIM_W'(1);
            cols_reg     <= DIM_W'(1);
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            row_base_reg <= '0;
            b_addr_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            inner_reg    <= inner_next;
            cols_reg     <= cols_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            row_base_reg <= row_base_next;
            b_addr_reg   <= b_addr_next;
        end
    end

    // Next state: issue inner reads per element, drain, then emit
    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        inner_next    = inner_reg;
        cols_next     = cols_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        row_base_next = row_base_reg;
        b_addr_next   = b_addr_reg;
        issue         = 1'b0;
        acc_clr       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_axis_tuser == MODE_COMPUTE))
                begin
                    rows_next     = dim_of(row_count_reg);
                    inner_next    = dim_of(inner_count_reg);
                    cols_next     = dim_of(col_count_reg);
                    i_next        = '0;
                    j_next        = '0;
                    k_next        = '0;
                    row_base_next = '0;
                    b_addr_next   = '0;
                    acc_clr       = 1'b1;
                    state_next    = ST_MAC;
                end
            end
            ST_MAC:
            begin
                issue       = 1'b1;
                k_next      = k_reg + IDX_W'(1);
                b_addr_next = b_addr_reg + {2'b00, cols_reg};
                if ({1'b0, k_reg} == inner_reg - DIM_W'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    acc_clr  = 1'b1;
                    k_next   = '0;
                    if ({1'b0, j_reg} == cols_reg - DIM_W'(1))
                    begin
                        j_next      = '0;
                        b_addr_next = '0;
                        if (last_elem)
                            state_next = ST_IDLE;
                        else
                        begin
                            i_next        = i_reg + IDX_W'(1);
                            row_base_next = row_base_reg + {2'b00, inner_reg};
                            state_next    = ST_MAC;
                        end
                    end
                    else
                    begin
                        j_next      = j_reg + IDX_W'(1);
                        b_addr_next = {3'b000, j_reg} + ADDR_W'(1);
                        state_next  = ST_MAC;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Track operands through read and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // Multiply and accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (acc_clr)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Output register: load a finished element, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_val_reg  <= sat32(acc_reg);
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_last_reg <= last_elem;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_val_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/mme_checker.sv =====
// Port-level assertions for the matrix multiply engine, bound to the top level.
module mme_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [mme_pkg::MODE_W-1:0]        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mme_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              m_axis_tlast
);
    import mme_pkg::*;

    // A compute transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COMPUTE) |=> !s_axis_tready)
        else $error("input still ready after compute transaction");

    // Load and unused-mode transactions keep the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_COMPUTE) |=> s_axis_tready)
        else $error("block went busy after a load transaction");

    // A non-final result only leaves while the run is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("non-final result while idle");

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);
